>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent check wrappers, compiled out when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// check sampled on the rising edge, masked while reset is asserted
`define SRC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// check sampled on the rising edge, also live during reset
`define SRC_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define SRC_ASSERT(label, clk, rst_n, prop)
`define SRC_ASSERT_NR(label, clk, prop)
`endif

`endif

>>> rtl/srcnt_pkg.sv
// ---------------------------------------------------------------------------
// srcnt_pkg
// fixed field widths, number formats and the result record of the
// systematic resampling copy counter
// ---------------------------------------------------------------------------
package srcnt_pkg;

    // number formats
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int OFFSET_BITS      = 16;
    localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 1;
    localparam int SUM_W            = WEIGHT_FRAC_BITS + 2;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // result field widths
    localparam int INDEX_W  = 10;
    localparam int COPIES_W = 11;

    // stream data widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // one result as it leaves the back end
    typedef struct packed {
        logic                too_many;
        logic                set_done;
        logic [COPIES_W-1:0] leftover;
        logic [COPIES_W-1:0] copies;
        logic [INDEX_W-1:0]  index;
    } t_result;

endpackage

>>> rtl/srcnt_fifo.sv
// ---------------------------------------------------------------------------
// srcnt_fifo
// small register queue between the front and back ends
// ---------------------------------------------------------------------------
module srcnt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             s_push, s_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (s_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (s_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (s_push && !s_pop) begin
            n_count = r_count + 1'b1;
        end else if (s_pop && !s_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/srcnt_front.sv
// ---------------------------------------------------------------------------
// srcnt_front
// takes weights in, keeps the saturating running sum, the particle position
// and the start offset of the set
// ---------------------------------------------------------------------------
module srcnt_front
    import srcnt_pkg::*;
#(
    parameter int PARTICLES = 1024,
    parameter int POS_W     = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [WEIGHT_W-1:0]    i_weight,
    input  logic [OFFSET_BITS-1:0] i_start_offset,
    input  logic                   i_last,
    output logic [SUM_W-1:0]       o_sum,
    output logic [OFFSET_BITS-1:0] o_offset,
    output logic [POS_W-1:0]       o_pos,
    output logic                   o_over,
    output logic                   o_last
);

    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [SUM_W:0]         s_sum_wide;
    logic [SUM_W-1:0]       s_sum_sat;
    logic                   s_first;
    logic                   s_over;

    assign s_first = (r_pos == '0);
    assign s_over  = (r_pos == POS_W'(PARTICLES));

    // saturating running sum
    assign s_sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(i_weight);
    assign s_sum_sat  = s_sum_wide[SUM_W] ? SUM_MAX : s_sum_wide[SUM_W-1:0];

    // offset latched from the first item of a set
    assign n_offset = s_first ? i_start_offset : r_offset;

    // set state advance, cleared on the last item
    always_comb begin
        n_sum = s_sum_sat;
        n_pos = s_over ? r_pos : r_pos + 1'b1;
        if (i_last) begin
            n_sum = '0;
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_pos    <= '0;
            r_offset <= '0;
        end else if (i_accept) begin
            r_sum    <= n_sum;
            r_pos    <= n_pos;
            r_offset <= n_offset;
        end
    end

    // request handed to the queue
    assign o_sum    = s_sum_sat;
    assign o_offset = n_offset;
    assign o_pos    = r_pos;
    assign o_over   = s_over;
    assign o_last   = i_last;

endmodule

>>> rtl/srcnt_back.sv
// ---------------------------------------------------------------------------
// srcnt_back
// three stage back end: scale the running sum, count the thresholds below
// it, then hand out the new copies against the total given so far
// ---------------------------------------------------------------------------
module srcnt_back
    import srcnt_pkg::*;
#(
    parameter int PARTICLES = 1024,
    parameter int POS_W     = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SUM_W-1:0]       i_sum,
    input  logic [OFFSET_BITS-1:0] i_offset,
    input  logic [POS_W-1:0]       i_pos,
    input  logic                   i_over,
    input  logic                   i_last,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_result                o_result
);

    localparam int PROD_W = SUM_W + POS_W;
    localparam int SCL_W  = PROD_W + OFFSET_BITS;
    localparam int SHIFT  = OFFSET_BITS + WEIGHT_FRAC_BITS;
    localparam int QUOT_W = SCL_W - SHIFT;
    localparam int CNT_W  = QUOT_W + 1;

    // stage a: scaled sum
    logic                   r_a_valid;
    logic [PROD_W-1:0]      r_a_prod;
    logic [OFFSET_BITS-1:0] r_a_offset;
    logic [POS_W-1:0]       r_a_pos;
    logic                   r_a_over;
    logic                   r_a_last;
    // stage b: thresholds reached
    logic                   r_b_valid;
    logic [POS_W-1:0]       r_b_reached;
    logic [POS_W-1:0]       r_b_pos;
    logic                   r_b_over;
    logic                   r_b_last;
    // stage c: output register
    logic                   r_c_valid;
    t_result                r_c_result, n_c_result;
    logic [POS_W-1:0]       r_issued, n_issued;

    logic                   s_adv_a, s_adv_b, s_adv_c;
    logic [SCL_W-1:0]       s_scaled, s_base, s_diff;
    logic [QUOT_W-1:0]      s_quot;
    logic [CNT_W-1:0]       s_cnt;
    logic [POS_W-1:0]       s_reached;
    logic [POS_W-1:0]       s_copies;
    logic [POS_W-1:0]       s_leftover;

    // stall chain
    assign s_adv_c = !r_c_valid || i_ready;
    assign s_adv_b = !r_b_valid || s_adv_c;
    assign s_adv_a = !r_a_valid || s_adv_b;
    assign o_ready = s_adv_a;

    // threshold count: ceil((sum*P*2^off_bits - off*2^frac) / 2^shift)
    assign s_scaled = {r_a_prod, {OFFSET_BITS{1'b0}}};
    assign s_base   = SCL_W'({r_a_offset, {WEIGHT_FRAC_BITS{1'b0}}});
    assign s_diff   = s_scaled - s_base - SCL_W'(1);
    assign s_quot   = s_diff[SCL_W-1 -: QUOT_W];
    assign s_cnt    = {1'b0, s_quot} + CNT_W'(1);

    always_comb begin
        priority if (s_scaled <= s_base) begin
            s_reached = '0;
        end else if (s_cnt > CNT_W'(PARTICLES)) begin
            s_reached = POS_W'(PARTICLES);
        end else begin
            s_reached = s_cnt[POS_W-1:0];
        end
    end

    // copies granted against the running total
    always_comb begin
        s_copies = '0;
        n_issued = r_issued;
        if (r_b_reached > r_issued) begin
            s_copies = r_b_reached - r_issued;
            n_issued = r_b_reached;
        end
        s_leftover = r_b_last ? POS_W'(PARTICLES) - n_issued : '0;
        n_c_result.too_many = r_b_over;
        n_c_result.set_done = r_b_last;
        n_c_result.leftover = COPIES_W'(s_leftover);
        n_c_result.copies   = COPIES_W'(s_copies);
        n_c_result.index    = INDEX_W'(r_b_pos);
    end

    // valid flags and the issued total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_issued  <= '0;
        end else begin
            if (s_adv_a) begin
                r_a_valid <= i_valid;
            end
            if (s_adv_b) begin
                r_b_valid <= r_a_valid;
            end
            if (s_adv_c) begin
                r_c_valid <= r_b_valid;
                if (r_b_valid) begin
                    r_issued <= r_b_last ? '0 : n_issued;
                end
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (s_adv_a) begin
            r_a_prod   <= PROD_W'(i_sum) * PROD_W'(PARTICLES);
            r_a_offset <= i_offset;
            r_a_pos    <= i_pos;
            r_a_over   <= i_over;
            r_a_last   <= i_last;
        end
        if (s_adv_b) begin
            r_b_reached <= s_reached;
            r_b_pos     <= r_a_pos;
            r_b_over    <= r_a_over;
            r_b_last    <= r_a_last;
        end
        if (s_adv_c) begin
            r_c_result <= n_c_result;
        end
    end

    assign o_valid  = r_c_valid;
    assign o_result = r_c_result;

endmodule

>>> rtl/systematic_resample_counts_top.sv
// ---------------------------------------------------------------------------
// systematic_resample_counts_top
// systematic resampling copy counter: per particle weight in, number of
// resampled slots it fills out, shortfall reported on the last particle
// ---------------------------------------------------------------------------
//  channel    dir  tdata (low bit up)                      tlast     tuser
//  s_axis     in   weight[16:0] start_offset[32:17] pad    last      -
//  m_axis     out  particle_index[9:0] copies[20:10]       set_done  too_many
//                  leftover_to_first[31:21]
//
//  one particle per cycle sustained while the queue is not full; the running
//  sum is a single saturating add in the front end, so the set order
//  dependency closes in the front end; the queue feeds scale, count, issue.
//  reset is synchronous, active low, and clears the set state and all queues.
//  the 4 entry queue lets the input keep going while the output is stalled.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module systematic_resample_counts_top
    import srcnt_pkg::*;
#(
    parameter int PARTICLES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // weight, start_offset, zero pad
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                 i_s_axis_tlast,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // particle_index, copies, leftover_to_first
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    output logic                 o_m_axis_tlast,
    // too_many
    output logic                 o_m_axis_tuser
);

    localparam int POS_W    = $clog2(PARTICLES + 1);
    localparam int ITEM_W   = 2 + POS_W + OFFSET_BITS + SUM_W;
    localparam int Q_DEPTH  = 4;

    logic                   s_accept;
    logic                   s_q_full;
    logic                   s_q_valid;
    logic                   s_q_pop;
    logic [ITEM_W-1:0]      s_q_wdata, s_q_rdata;
    logic [SUM_W-1:0]       s_f_sum, s_b_sum;
    logic [OFFSET_BITS-1:0] s_f_offset, s_b_offset;
    logic [POS_W-1:0]       s_f_pos, s_b_pos;
    logic                   s_f_over, s_b_over;
    logic                   s_f_last, s_b_last;
    logic                   s_b_ready;
    t_result                s_result;

    assign o_s_axis_tready = !s_q_full;
    assign s_accept        = i_s_axis_tvalid && !s_q_full;

    // front end
    srcnt_front #(
        .PARTICLES (PARTICLES),
        .POS_W     (POS_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (s_accept),
        .i_weight       (i_s_axis_tdata[WEIGHT_W-1:0]),
        .i_start_offset (i_s_axis_tdata[WEIGHT_W +: OFFSET_BITS]),
        .i_last         (i_s_axis_tlast),
        .o_sum          (s_f_sum),
        .o_offset       (s_f_offset),
        .o_pos          (s_f_pos),
        .o_over         (s_f_over),
        .o_last         (s_f_last)
    );

    // queue between the two ends
    assign s_q_wdata = {s_f_last, s_f_over, s_f_pos, s_f_offset, s_f_sum};
    assign {s_b_last, s_b_over, s_b_pos, s_b_offset, s_b_sum} = s_q_rdata;
    assign s_q_pop   = s_b_ready;

    srcnt_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_accept),
        .i_data  (s_q_wdata),
        .o_full  (s_q_full),
        .i_pop   (s_q_pop),
        .o_valid (s_q_valid),
        .o_data  (s_q_rdata)
    );

    // back end
    srcnt_back #(
        .PARTICLES (PARTICLES),
        .POS_W     (POS_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_q_valid),
        .o_ready  (s_b_ready),
        .i_sum    (s_b_sum),
        .i_offset (s_b_offset),
        .i_pos    (s_b_pos),
        .i_over   (s_b_over),
        .i_last   (s_b_last),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (s_result)
    );

    // output packing
    assign o_m_axis_tdata = {s_result.leftover, s_result.copies, s_result.index};
    assign o_m_axis_tlast = s_result.set_done;
    assign o_m_axis_tuser = s_result.too_many;

    // checks
    `SRC_ASSERT_NR(a_out_idle_after_reset, i_clk, !i_rst_n |=> !o_m_axis_tvalid)
    `SRC_ASSERT(a_no_push_when_full, i_clk, i_rst_n, s_q_full |-> !s_accept)
    `SRC_ASSERT(a_leftover_only_on_last, i_clk, i_rst_n, (o_m_axis_tvalid && !o_m_axis_tlast) |-> (s_result.leftover == '0))
    `SRC_ASSERT(a_overflow_index, i_clk, i_rst_n, (o_m_axis_tvalid && o_m_axis_tuser) |-> (s_result.index == INDEX_W'(PARTICLES)))

endmodule
